// File: src/tmvc_pkg.sv
// shared types, operation table and helper functions for the mesh volume/centroid block
// no dependencies; used by tmvc_mac, tmvc_div and triangle_mesh_volume_centroid
package tmvc_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int OPA_W   = 35;
    localparam int OPB_W   = 19;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int SQ_W    = 34;
    localparam int SUM_W   = 64;
    localparam int QUO_W   = 16;
    localparam int STEP_W  = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(27);

    typedef enum logic [3:0] {
        A_D1X, A_D1Y, A_D1Z, A_N0, A_N1, A_N2,
        A_SAB_X, A_SBC_X, A_SCA_X,
        A_SAB_Y, A_SBC_Y, A_SCA_Y,
        A_SAB_Z, A_SBC_Z, A_SCA_Z
    } a_sel_t;

    typedef enum logic [3:0] {
        B_D2X, B_D2Y, B_D2Z, B_AX, B_AY, B_AZ, B_SAME,
        B_HI_X, B_HI_Y, B_HI_Z, B_LO_X, B_LO_Y, B_LO_Z
    } b_sel_t;

    typedef enum logic [2:0] {
        M_LOAD, M_ADD, M_SUB, M_SHR, M_HOLD
    } acc_mode_t;

    typedef enum logic [3:0] {
        D_NONE, D_N0, D_N1, D_N2, D_SQX, D_SQY, D_SQZ, D_VOL, D_MX, D_MY, D_MZ
    } dst_t;

    typedef struct packed {
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        acc_mode_t mode;
        dst_t      dst;
    } op_t;

    typedef struct packed {
        logic      mul_en;
        logic      acc_en;
        acc_mode_t mode;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_VDIV, S_CSTART, S_CWAIT, S_OUT
    } state_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [SUM_W-1:0] sum;
    } sat_res_t;

    function automatic op_t op_cmd(input logic [STEP_W-1:0] step);
        op_t o;
        o = '{a_sel: A_D1X, b_sel: B_D2X, mode: M_HOLD, dst: D_NONE};
        unique case (step)
            5'd0:  o = '{A_D1Y, B_D2Z, M_LOAD, D_NONE};
            5'd1:  o = '{A_D1Z, B_D2Y, M_SUB,  D_N0};
            5'd2:  o = '{A_D1Z, B_D2X, M_LOAD, D_NONE};
            5'd3:  o = '{A_D1X, B_D2Z, M_SUB,  D_N1};
            5'd4:  o = '{A_D1X, B_D2Y, M_LOAD, D_NONE};
            5'd5:  o = '{A_D1Y, B_D2X, M_SUB,  D_N2};
            5'd6:  o = '{A_N0,  B_AX,  M_LOAD, D_NONE};
            5'd7:  o = '{A_N1,  B_AY,  M_ADD,  D_NONE};
            5'd8:  o = '{A_N2,  B_AZ,  M_ADD,  D_NONE};
            5'd9:  o = '{A_D1X, B_D2X, M_HOLD, D_VOL};
            5'd10: o = '{A_SAB_X, B_SAME, M_LOAD, D_NONE};
            5'd11: o = '{A_SBC_X, B_SAME, M_ADD,  D_NONE};
            5'd12: o = '{A_SCA_X, B_SAME, M_ADD,  D_SQX};
            5'd13: o = '{A_N0,  B_LO_X, M_SHR,  D_NONE};
            5'd14: o = '{A_N0,  B_HI_X, M_ADD,  D_NONE};
            5'd15: o = '{A_D1X, B_D2X,  M_HOLD, D_MX};
            5'd16: o = '{A_SAB_Y, B_SAME, M_LOAD, D_NONE};
            5'd17: o = '{A_SBC_Y, B_SAME, M_ADD,  D_NONE};
            5'd18: o = '{A_SCA_Y, B_SAME, M_ADD,  D_SQY};
            5'd19: o = '{A_N1,  B_LO_Y, M_SHR,  D_NONE};
            5'd20: o = '{A_N1,  B_HI_Y, M_ADD,  D_NONE};
            5'd21: o = '{A_D1X, B_D2X,  M_HOLD, D_MY};
            5'd22: o = '{A_SAB_Z, B_SAME, M_LOAD, D_NONE};
            5'd23: o = '{A_SBC_Z, B_SAME, M_ADD,  D_NONE};
            5'd24: o = '{A_SCA_Z, B_SAME, M_ADD,  D_SQZ};
            5'd25: o = '{A_N2,  B_LO_Z, M_SHR,  D_NONE};
            5'd26: o = '{A_N2,  B_HI_Z, M_ADD,  D_NONE};
            5'd27: o = '{A_D1X, B_D2X,  M_HOLD, D_MZ};
            default: o = '{A_D1X, B_D2X, M_HOLD, D_NONE};
        endcase
        return o;
    endfunction

    function automatic sat_res_t sat_add(input logic signed [SUM_W-1:0] a,
                                         input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        sat_res_t r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        r.ovf = s[SUM_W] != s[SUM_W-1];
        if (r.ovf)
        begin
            r.sum = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r.sum = s[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] abs64(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    // four steps of long division by six: {remainder, quotient nibble}
    function automatic logic [6:0] div6_nib(input logic [2:0] rem, input logic [3:0] nib);
        logic [3:0] r;
        logic [3:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            r = {r[2:0], nib[i]};
            if (r >= 4'd6)
            begin
                r = r - 4'd6;
                q[i] = 1'b1;
            end
        end
        return {r[2:0], q};
    endfunction

endpackage

// File: src/tmvc_mac.sv
// shared multiplier-accumulator: registered product, then a 64-bit accumulator
// depends on tmvc_pkg
module tmvc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tmvc_pkg::mac_ctl_t                  ctl,
    input  logic signed [tmvc_pkg::OPA_W-1:0]   op_a,
    input  logic signed [tmvc_pkg::OPB_W-1:0]   op_b,
    output logic signed [tmvc_pkg::SUM_W-1:0]   acc,
    output logic signed [tmvc_pkg::SUM_W-1:0]   acc_next
);
    import tmvc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [PROD_W-1:0] prod_shr;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod_ext = SUM_W'(prod_reg);
    assign prod_shr = prod_reg >>> 16;

    always_comb
    begin
        unique case (ctl.mode)
            M_LOAD:  acc_next = prod_ext;
            M_ADD:   acc_next = acc_reg + prod_ext;
            M_SUB:   acc_next = acc_reg - prod_ext;
            M_SHR:   acc_next = SUM_W'(prod_shr);
            M_HOLD:  acc_next = acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: src/tmvc_div.sv
// restoring divider: floor(um * 2^13 / us), 16 quotient bits, one bit a cycle
// depends on tmvc_pkg
module tmvc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tmvc_pkg::SUM_W-1:0]        um,
    input  logic [tmvc_pkg::SUM_W-1:0]        us,
    output logic [tmvc_pkg::QUO_W-1:0]        quo,
    output logic                              big,
    output logic                              done
);
    import tmvc_pkg::*;

    localparam int R_W = SUM_W + 3;

    logic             busy_reg;
    logic [3:0]       cnt_reg;
    logic [R_W-1:0]   r_reg;
    logic [R_W-1:0]   dv_reg;
    logic [QUO_W-1:0] q_reg;
    logic             big_reg;
    logic             done_reg;

    logic [R_W-1:0]   dv_init;
    logic             too_big;
    logic [R_W:0]     r2;
    logic             ge;
    logic [R_W:0]     r2_sub;

    assign dv_init = {us, 3'b000};
    assign too_big = {3'b000, um} >= dv_init;
    assign r2      = {r_reg, 1'b0};
    assign ge      = r2 >= {1'b0, dv_reg};
    assign r2_sub  = r2 - {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'hf)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg  <= dv_init;
            big_reg <= too_big;
            r_reg   <= too_big ? '0 : {3'b000, um};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? r2_sub[R_W-1:0] : r2[R_W-1:0];
            q_reg <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign quo  = q_reg;
    assign big  = big_reg;
    assign done = done_reg;

endmodule

// File: src/triangle_mesh_volume_centroid.sv
// Signed volume and centroid of a closed triangle mesh, one triangle per input beat.
// A non-final triangle runs 28 steps, each a multiply state then an accumulate state,
// through one shared 35x19 multiplier and 64-bit accumulator, then returns to idle and ready.
// The beat flagged by tlast then divides the volume by 6 (a nibble a cycle), then runs
// each axis through the bit-serial centroid divider (skipped on zero volume),
// and the result waits in the output register until taken; the sums then clear.
// Depends on tmvc_pkg, tmvc_mac and tmvc_div.
module triangle_mesh_volume_centroid (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [143:0] s_axis_tdata,
    // final_triangle
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mesh_volume, center_x, center_y, center_z
    output logic [111:0] m_axis_tdata,
    // volume_is_zero, overflowed
    output logic [1:0]   m_axis_tuser
);
    import tmvc_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        axis_reg, axis_next;
    logic [3:0]        v6_cnt_reg, v6_cnt_next;

    logic signed [COORD_W-1:0] va_reg [3];
    logic signed [COORD_W-1:0] vb_reg [3];
    logic signed [COORD_W-1:0] vc_reg [3];
    logic                      last_reg;

    logic signed [OPA_W-1:0]   n_reg [3];
    logic [SQ_W-1:0]           sq_reg [3];
    logic signed [SUM_W-1:0]   vol_reg;
    logic signed [SUM_W-1:0]   m_reg [3];
    logic                      sat_reg;

    logic [SUM_W-1:0]          v6_u_reg;
    logic [SUM_W-1:0]          v6_q_reg;
    logic [2:0]                v6_rem_reg;
    logic signed [SUM_W-1:0]   mesh_volume_reg;
    logic signed [COORD_W-1:0] center_reg [3];
    logic                      vzero_reg;
    logic                      cen_ovf_reg;

    logic signed [DIFF_W-1:0]  d1 [3];
    logic signed [DIFF_W-1:0]  d2 [3];
    logic signed [DIFF_W-1:0]  s_ab [3];
    logic signed [DIFF_W-1:0]  s_bc [3];
    logic signed [DIFF_W-1:0]  s_ca [3];

    op_t                       op;
    mac_ctl_t                  mac_ctl;
    logic signed [OPA_W-1:0]   op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [SUM_W-1:0]   acc;
    logic signed [SUM_W-1:0]   acc_next;
    sat_res_t                  sat_res;
    logic signed [SUM_W-1:0]   sat_in;

    logic                      div_start;
    logic [SUM_W-1:0]          div_um;
    logic [SUM_W-1:0]          div_us;
    logic [QUO_W-1:0]          div_quo;
    logic                      div_big;
    logic                      div_done;

    logic [6:0]                v6_nib;
    logic [SUM_W-1:0]          v6_q_fin;
    logic                      c_neg;
    logic [QUO_W:0]            c_limit;
    logic                      c_sat;
    logic [QUO_W:0]            c_neg_q;
    logic signed [COORD_W-1:0] c_val;

    logic in_beat;
    logic out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k]   = DIFF_W'(vb_reg[k]) - DIFF_W'(va_reg[k]);
            d2[k]   = DIFF_W'(vc_reg[k]) - DIFF_W'(va_reg[k]);
            s_ab[k] = DIFF_W'(va_reg[k]) + DIFF_W'(vb_reg[k]);
            s_bc[k] = DIFF_W'(vb_reg[k]) + DIFF_W'(vc_reg[k]);
            s_ca[k] = DIFF_W'(vc_reg[k]) + DIFF_W'(va_reg[k]);
        end
    end

    assign op = op_cmd(step_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (op.a_sel)
            A_D1X:   op_a = OPA_W'(d1[0]);
            A_D1Y:   op_a = OPA_W'(d1[1]);
            A_D1Z:   op_a = OPA_W'(d1[2]);
            A_N0:    op_a = n_reg[0];
            A_N1:    op_a = n_reg[1];
            A_N2:    op_a = n_reg[2];
            A_SAB_X: op_a = OPA_W'(s_ab[0]);
            A_SBC_X: op_a = OPA_W'(s_bc[0]);
            A_SCA_X: op_a = OPA_W'(s_ca[0]);
            A_SAB_Y: op_a = OPA_W'(s_ab[1]);
            A_SBC_Y: op_a = OPA_W'(s_bc[1]);
            A_SCA_Y: op_a = OPA_W'(s_ca[1]);
            A_SAB_Z: op_a = OPA_W'(s_ab[2]);
            A_SBC_Z: op_a = OPA_W'(s_bc[2]);
            A_SCA_Z: op_a = OPA_W'(s_ca[2]);
            default: op_a = '0;
        endcase
        unique case (op.b_sel)
            B_D2X:   op_b = OPB_W'(d2[0]);
            B_D2Y:   op_b = OPB_W'(d2[1]);
            B_D2Z:   op_b = OPB_W'(d2[2]);
            B_AX:    op_b = OPB_W'(va_reg[0]);
            B_AY:    op_b = OPB_W'(va_reg[1]);
            B_AZ:    op_b = OPB_W'(va_reg[2]);
            B_SAME:  op_b = op_a[OPB_W-1:0];
            B_HI_X:  op_b = {1'b0, sq_reg[0][SQ_W-1:16]};
            B_HI_Y:  op_b = {1'b0, sq_reg[1][SQ_W-1:16]};
            B_HI_Z:  op_b = {1'b0, sq_reg[2][SQ_W-1:16]};
            B_LO_X:  op_b = {3'b000, sq_reg[0][15:0]};
            B_LO_Y:  op_b = {3'b000, sq_reg[1][15:0]};
            B_LO_Z:  op_b = {3'b000, sq_reg[2][15:0]};
            default: op_b = '0;
        endcase
    end

    assign mac_ctl.mul_en = state_reg == S_MUL;
    assign mac_ctl.acc_en = state_reg == S_ACC;
    assign mac_ctl.mode   = op.mode;

    tmvc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc      (acc),
        .acc_next (acc_next)
    );

    always_comb
    begin
        unique case (op.dst)
            D_MX:    sat_in = m_reg[0];
            D_MY:    sat_in = m_reg[1];
            D_MZ:    sat_in = m_reg[2];
            default: sat_in = vol_reg;
        endcase
    end

    assign sat_res = sat_add(sat_in, acc);

    // centroid divider
    assign div_start = state_reg == S_CSTART;
    assign div_um    = abs64(m_reg[axis_reg]);
    assign div_us    = abs64(vol_reg);

    tmvc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .um    (div_um),
        .us    (div_us),
        .quo   (div_quo),
        .big   (div_big),
        .done  (div_done)
    );

    assign c_neg   = m_reg[axis_reg][SUM_W-1] != vol_reg[SUM_W-1];
    assign c_limit = c_neg ? 17'd32768 : 17'd32767;
    assign c_sat   = div_big || ({1'b0, div_quo} > c_limit);
    assign c_neg_q = -{1'b0, div_quo};
    always_comb
    begin
        if (c_sat)
        begin
            c_val = c_neg ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            c_val = c_neg ? c_neg_q[COORD_W-1:0] : div_quo;
        end
    end

    // volume / 6, most significant nibble first
    assign v6_nib   = div6_nib(v6_rem_reg, v6_u_reg[SUM_W-1 -: 4]);
    assign v6_q_fin = {v6_q_reg[SUM_W-5:0], v6_nib[3:0]};

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        axis_next   = axis_reg;
        v6_cnt_next = v6_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (step_reg == LAST_STEP)
                begin
                    v6_cnt_next = '0;
                    state_next  = last_reg ? S_VDIV : S_IDLE;
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = S_MUL;
                end
            end
            S_VDIV:
            begin
                v6_cnt_next = v6_cnt_reg + 4'd1;
                if (v6_cnt_reg == 4'hf)
                begin
                    axis_next  = '0;
                    state_next = (vol_reg == '0) ? S_OUT : S_CSTART;
                end
            end
            S_CSTART:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_CSTART;
                    end
                end
            end
            S_OUT:
            begin
                if (out_beat)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            axis_reg   <= '0;
            v6_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            axis_reg   <= axis_next;
            v6_cnt_reg <= v6_cnt_next;
        end
    end

    // accumulated mesh state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg <= '0;
            sat_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k] <= '0;
            end
        end
        else if (state_reg == S_OUT && out_beat)
        begin
            vol_reg <= '0;
            sat_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k] <= '0;
            end
        end
        else if (state_reg == S_ACC)
        begin
            unique case (op.dst)
                D_VOL:
                begin
                    vol_reg <= sat_res.sum;
                    sat_reg <= sat_reg | sat_res.ovf;
                end
                D_MX:
                begin
                    m_reg[0] <= sat_res.sum;
                    sat_reg  <= sat_reg | sat_res.ovf;
                end
                D_MY:
                begin
                    m_reg[1] <= sat_res.sum;
                    sat_reg  <= sat_reg | sat_res.ovf;
                end
                D_MZ:
                begin
                    m_reg[2] <= sat_res.sum;
                    sat_reg  <= sat_reg | sat_res.ovf;
                end
                default:
                begin
                end
            endcase
        end
    end

    // triangle payload and intermediate products
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            for (int k = 0; k < 3; k++)
            begin
                va_reg[k] <= s_axis_tdata[16*k +: 16];
                vb_reg[k] <= s_axis_tdata[48 + 16*k +: 16];
                vc_reg[k] <= s_axis_tdata[96 + 16*k +: 16];
            end
            last_reg <= s_axis_tlast;
        end
        if (state_reg == S_ACC)
        begin
            unique case (op.dst)
                D_N0:    n_reg[0]  <= acc_next[OPA_W-1:0];
                D_N1:    n_reg[1]  <= acc_next[OPA_W-1:0];
                D_N2:    n_reg[2]  <= acc_next[OPA_W-1:0];
                D_SQX:   sq_reg[0] <= acc_next[SQ_W-1:0];
                D_SQY:   sq_reg[1] <= acc_next[SQ_W-1:0];
                D_SQZ:   sq_reg[2] <= acc_next[SQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // result stage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC && step_reg == LAST_STEP)
        begin
            v6_u_reg    <= abs64(vol_reg);
            v6_q_reg    <= '0;
            v6_rem_reg  <= '0;
            cen_ovf_reg <= 1'b0;
            vzero_reg   <= 1'b0;
        end
        else if (state_reg == S_VDIV)
        begin
            v6_u_reg   <= {v6_u_reg[SUM_W-5:0], 4'h0};
            v6_q_reg   <= v6_q_fin;
            v6_rem_reg <= v6_nib[6:4];
            if (v6_cnt_reg == 4'hf)
            begin
                mesh_volume_reg <= vol_reg[SUM_W-1] ? SUM_W'(-v6_q_fin) : v6_q_fin;
                if (vol_reg == '0)
                begin
                    vzero_reg <= 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        center_reg[k] <= '0;
                    end
                end
            end
        end
        else if (state_reg == S_CWAIT && div_done)
        begin
            center_reg[axis_reg] <= c_val;
            cen_ovf_reg          <= cen_ovf_reg | c_sat;
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = state_reg == S_OUT;
    assign m_axis_tdata  = {center_reg[2], center_reg[1], center_reg[0], mesh_volume_reg};
    assign m_axis_tuser  = {sat_reg | cen_ovf_reg, vzero_reg};

endmodule
